/* rtl/cfd_pkg.sv */
// Shared constants, types and register indexes of the constant-fraction timing block.
// No dependencies; cfd_if and the top level import this package.
package cfd_pkg;

  localparam int unsigned BINS         = 256;
  localparam int unsigned MAX_DELAY    = 64;
  localparam int unsigned SAMPLE_WIDTH = 24;

  localparam int unsigned DELAY_W  = 7;
  localparam int unsigned BW_W     = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned BIN_W    = $clog2(BINS + 1);
  localparam int unsigned CBIN_W   = $clog2(BINS);
  localparam int unsigned SLOT_W   = $clog2(MAX_DELAY);
  localparam int unsigned DISC_W   = SAMPLE_WIDTH + 4;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned TIME_W   = 19;
  localparam int unsigned CHARGE_W = 24;
  localparam int unsigned FRAC_W   = 8;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [TIME_W-1:0]       cfd_time_t;
  typedef logic signed [CHARGE_W-1:0]     charge_t;
  typedef logic signed [ACC_W-1:0]        acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_BINS = 1'b0,
    CFG_BIN_WIDTH  = 1'b1
  } cfg_idx_e;

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(8);
  localparam logic [DELAY_W-1:0] DELAY_MAX   = DELAY_W'(MAX_DELAY);
  localparam logic [BW_W-1:0]    BW_RESET    = BW_W'(1);

  localparam cfd_time_t NO_CROSS_TIME = -TIME_W'(1024);

  localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'(2147483647);
  localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W+1)'(33'sd2147483648);
  localparam logic signed [ACC_W:0] CHARGE_MAX = (ACC_W+1)'(8388607);
  localparam logic signed [ACC_W:0] CHARGE_MIN = -(ACC_W+1)'(8388608);
  localparam logic signed [ACC_W:0] RND_POS = (ACC_W+1)'(128);
  localparam logic signed [ACC_W:0] RND_NEG = (ACC_W+1)'(127);

endpackage

/* rtl/cfd_if.sv */
// Valid/ready channels of the constant-fraction timing block: sample input and result output.
// Depends on cfd_pkg.
interface cfd_in_if;
  import cfd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface cfd_out_if;
  import cfd_pkg::*;

  logic      valid;
  logic      ready;
  logic      found;
  cfd_time_t cfd_time;
  charge_t   charge;

  modport source (output valid, output found, output cfd_time, output charge, input ready);
  modport sink   (input valid, input found, input cfd_time, input charge, output ready);
endinterface

/* rtl/cfd_ram.sv */
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module cfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cfd_timing_and_charge_integrator.sv */
// Top level of the constant-fraction timing and charge integrator.
// Depends on cfd_pkg, cfd_if (cfd_in_if, cfd_out_if) and cfd_ram.
//
//   channel   direction  request content
//   in_i      sink       sample (signed, 8 fraction bits), last
//   out_o     source     found, cfd_time, charge (one per window)
//   cfg_*     write      cfg_idx_i 0: delay_bins, 1: bin_width
//
// One sample is accepted every cycle while stage 1 is free; three register
// stages (sample/delay-line read, window accumulation, result formatting) carry
// a window's last sample through stage 1 and stage 2 into the result register
// on out_o. The delay-line RAM read port sets the first stage. A stalled out_o
// holds its result and backs up through the stages to in_i.ready. Reset restores
// the register defaults and empties the window; the delay line needs no clearing.
module cfd_timing_and_charge_integrator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cfd_in_if.sink                           in_i,
  cfd_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cfd_pkg::CFG_W-1:0]        cfg_data_i
);
  import cfd_pkg::*;

  // Configuration
  logic [DELAY_W-1:0] delay_q;
  logic [BW_W-1:0]    bw_q;
  logic [DELAY_W-1:0] d_eff;

  // Accept stage
  logic               in_acc;
  logic [BIN_W-1:0]   bin_q, bin_d;
  logic               in_active;
  logic [BIN_W-1:0]   rd_diff;
  sample_t            line_rd;

  // Stage 1: accepted sample
  logic               s1_vld_q, s1_vld_d;
  sample_t            s1_sample_q;
  logic               s1_last_q;
  logic [BIN_W-1:0]   s1_bin_q;
  logic               s1_prompt_q;
  logic               s1_self_q;
  logic               s1_go;
  logic               s1_free;

  // Window state
  logic               prev_neg_q, prev_neg_d;
  logic               seen_q, seen_d;
  logic [CBIN_W-1:0]  cbin_q, cbin_d;
  acc_t               sum_q, sum_d;
  sample_t            disc_a;
  logic signed [DISC_W-1:0] disc;
  logic               disc_neg;
  logic signed [ACC_W:0]    sum_ext;
  acc_t               sum_sat;
  logic               upd_seen;
  logic [CBIN_W-1:0]  upd_cbin;
  acc_t               upd_sum;
  logic               upd_neg;

  // Stage 2: closed window
  logic               fin_vld_q, fin_vld_d;
  logic               fin_found_q;
  logic [CBIN_W-1:0]  fin_cbin_q;
  acc_t               fin_sum_q;
  logic               fin_load;
  logic               fin_go;
  logic               fin_free;

  // Stage 3: result register
  logic               out_vld_q, out_vld_d;
  logic               out_found_q;
  cfd_time_t          out_time_q, out_time_d;
  charge_t            out_charge_q, out_charge_d;
  logic               out_free;
  logic [CBIN_W+BW_W-1:0]   prod;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W:0]    q_full;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
      bw_q    <= BW_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY_BINS: delay_q <= cfg_data_i[DELAY_W-1:0];
        CFG_BIN_WIDTH:  bw_q    <= cfg_data_i[BW_W-1:0];
        default:        delay_q <= delay_q;
      endcase
    end
  end

  assign d_eff = (delay_q > DELAY_MAX) ? DELAY_MAX : delay_q;

  // ---------------------------------------------------------------- handshake
  assign out_free = !out_vld_q || out_o.ready;
  assign fin_go   = fin_vld_q && out_free;
  assign fin_free = !fin_vld_q || out_free;
  assign s1_go    = s1_vld_q && (!s1_last_q || fin_free);
  assign s1_free  = !s1_vld_q || s1_go;
  assign in_i.ready = s1_free;
  assign in_acc   = in_i.valid && s1_free;

  // ---------------------------------------------------------------- accept stage
  assign in_active = bin_q < BIN_W'(BINS);
  assign rd_diff   = bin_q - BIN_W'(d_eff);

  always_comb begin
    bin_d = bin_q;
    if (in_acc) begin
      if (in_i.last) begin
        bin_d = '0;
      end else if (in_active) begin
        bin_d = bin_q + BIN_W'(1);
      end
    end
  end

  cfd_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_active),
    .waddr_i (bin_q[SLOT_W-1:0]),
    .wdata_i (in_i.sample),
    .re_i    (in_acc),
    .raddr_i (rd_diff[SLOT_W-1:0]),
    .rdata_o (line_rd)
  );

  assign s1_vld_d = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_vld_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= in_i.sample;
      s1_last_q   <= in_i.last;
      s1_bin_q    <= bin_q;
      s1_prompt_q <= bin_q < BIN_W'(d_eff);
      s1_self_q   <= d_eff == '0;
    end
  end

  // ---------------------------------------------------------------- window stage
  // Before the delay has filled, the delayed term is zero; with no delay the
  // sample is its own delayed copy, which gives four times the sample.
  always_comb begin
    if (s1_prompt_q) begin
      disc_a = '0;
    end else if (s1_self_q) begin
      disc_a = s1_sample_q;
    end else begin
      disc_a = line_rd;
    end
  end

  assign disc     = (DISC_W'(disc_a) <<< 2) + DISC_W'(disc_a) - DISC_W'(s1_sample_q);
  assign disc_neg = disc[DISC_W-1];

  assign sum_ext = (ACC_W+1)'(sum_q) + (ACC_W+1)'(s1_sample_q);
  always_comb begin
    if (sum_ext > ACC_MAX) begin
      sum_sat = ACC_MAX[ACC_W-1:0];
    end else if (sum_ext < ACC_MIN) begin
      sum_sat = ACC_MIN[ACC_W-1:0];
    end else begin
      sum_sat = sum_ext[ACC_W-1:0];
    end
  end

  always_comb begin
    upd_seen = seen_q;
    upd_cbin = cbin_q;
    upd_sum  = sum_q;
    upd_neg  = prev_neg_q;
    // Bins past the window length do not count.
    if (!s1_bin_q[BIN_W-1]) begin
      if (!seen_q && s1_bin_q != '0 && prev_neg_q && !disc_neg) begin
        upd_seen = 1'b1;
        upd_cbin = s1_bin_q[CBIN_W-1:0];
      end
      upd_neg = disc_neg;
      upd_sum = sum_sat;
    end
  end

  assign fin_load = s1_go && s1_last_q;

  always_comb begin
    seen_d     = seen_q;
    cbin_d     = cbin_q;
    sum_d      = sum_q;
    prev_neg_d = prev_neg_q;
    if (s1_go) begin
      if (s1_last_q) begin
        seen_d     = 1'b0;
        cbin_d     = '0;
        sum_d      = '0;
        prev_neg_d = 1'b0;
      end else begin
        seen_d     = upd_seen;
        cbin_d     = upd_cbin;
        sum_d      = upd_sum;
        prev_neg_d = upd_neg;
      end
    end
  end

  assign fin_vld_d = fin_load ? 1'b1 : (fin_go ? 1'b0 : fin_vld_q);

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_found_q <= upd_seen;
      fin_cbin_q  <= upd_cbin;
      fin_sum_q   <= upd_sum;
    end
  end

  // ---------------------------------------------------------------- result stage
  assign prod = (CBIN_W+BW_W)'(fin_cbin_q) * (CBIN_W+BW_W)'(bw_q);
  assign out_time_d = fin_found_q ? cfd_time_t'(TIME_W'(prod)) : NO_CROSS_TIME;

  // Round half away from zero: negative sums take one less before the floor shift.
  assign rnd    = (ACC_W+1)'(fin_sum_q) + (fin_sum_q[ACC_W-1] ? RND_NEG : RND_POS);
  assign q_full = rnd >>> FRAC_W;

  always_comb begin
    if (q_full > CHARGE_MAX) begin
      out_charge_d = CHARGE_MAX[CHARGE_W-1:0];
    end else if (q_full < CHARGE_MIN) begin
      out_charge_d = CHARGE_MIN[CHARGE_W-1:0];
    end else begin
      out_charge_d = q_full[CHARGE_W-1:0];
    end
  end

  assign out_vld_d = fin_go ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_found_q  <= fin_found_q;
      out_time_q   <= out_time_d;
      out_charge_q <= out_charge_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.found    = out_found_q;
  assign out_o.cfd_time = out_time_q;
  assign out_o.charge   = out_charge_q;

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q      <= '0;
      s1_vld_q   <= 1'b0;
      prev_neg_q <= 1'b0;
      seen_q     <= 1'b0;
      cbin_q     <= '0;
      sum_q      <= '0;
      fin_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      bin_q      <= bin_d;
      s1_vld_q   <= s1_vld_d;
      prev_neg_q <= prev_neg_d;
      seen_q     <= seen_d;
      cbin_q     <= cbin_d;
      sum_q      <= sum_d;
      fin_vld_q  <= fin_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

`ifndef SYNTHESIS
  a_bin_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_q <= BIN_W'(BINS))
    else $error("bin counter beyond window length");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last |=> bin_q == '0)
    else $error("bin counter not restarted after last sample");

  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> !seen_q && !prev_neg_q && sum_q == '0 && cbin_q == '0)
    else $error("window state not cleared after close");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q && !out_free |=> fin_vld_q && $stable(fin_sum_q) && $stable(fin_cbin_q))
    else $error("closed window lost while result stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |-> fin_free)
    else $error("window closed into a full result stage");
`endif

endmodule
